[src/glof_pkg.sv]
// Shared types and defaults for the glyph outline flattener.
// No dependencies; imported by glof_div and glyph_outline_flattener.
package glof_pkg;

   // Default coordinate width (signed 18.6 outline units)
   localparam int COORD_WIDTH_DEFAULT = 24;

   // Outline command codes
   typedef enum logic [2:0] {
      ACT_MOVE  = 3'd0,
      ACT_LINE  = 3'd1,
      ACT_CONIC = 3'd2,
      ACT_CUBIC = 3'd3,
      ACT_GLYPH = 3'd4
   } glof_action_type;

   // What a command leaves in the pipeline
   typedef enum logic [1:0] {
      MODE_VERTEX = 2'd0,   // one vertex
      MODE_MARKER = 2'd1,   // contour marker, then one vertex
      MODE_CURVE  = 2'd2    // two interior points, then the end point
   } glof_mode_type;

   // Per-stage load enables handed to the dividers
   typedef struct packed {
      logic mul;   // load partial products
      logic est;   // load quotient estimate
      logic fix;   // load corrected quotient
   } glof_en_type;

endpackage

[src/glof_div.sv]
// Three-stage flooring divider by 9 (conic) or 27 (cubic) for one coordinate.
// Depends on glof_pkg (glof_en_type).
module glof_div #(
   parameter int COORD_WIDTH = glof_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  glof_pkg::glof_en_type         en,
   input  logic                          cubic,
   input  logic [COORD_WIDTH+4:0]        dividend,
   output logic signed [COORD_WIDTH-1:0] quot
);
   import glof_pkg::*;

   localparam int UW  = COORD_WIDTH + 5;   // biased dividend width
   localparam int MW  = UW - 3;            // reciprocal width
   localparam int HW  = MW / 2;            // low partial product split
   localparam int HHW = MW - HW;
   localparam logic [MW-1:0] RECIP9  = MW'((64'd1 << UW) / 64'd9);
   localparam logic [MW-1:0] RECIP27 = MW'((64'd1 << UW) / 64'd27);

   logic [MW-1:0]        recip;
   logic [UW+HW-1:0]     plo_ff,  plo_in;
   logic [UW+HHW-1:0]    phi_ff,  phi_in;
   logic [UW-1:0]        u_a_ff,  u_b_ff;
   logic                 cub_a_ff, cub_b_ff;
   logic [UW+MW-1:0]     prod;
   logic [COORD_WIDTH-1:0] qe_ff, qe_in;
   logic [UW-1:0]        qden;
   logic [UW-1:0]        rem;
   logic [UW-1:0]        den;
   logic [COORD_WIDTH-1:0] q;

   // Stage one: reciprocal multiply split into two partial products
   always_comb begin
      recip  = cubic ? RECIP27 : RECIP9;
      plo_in = (UW+HW)'(dividend) * (UW+HW)'(recip[HW-1:0]);
      phi_in = (UW+HHW)'(dividend) * (UW+HHW)'(recip[MW-1:HW]);
   end

   // Stage two: combine products; estimate is the true quotient or one less
   always_comb begin
      prod  = {phi_ff, HW'(0)} + (UW+MW)'(plo_ff);
      qe_in = prod[UW+COORD_WIDTH-1:UW];
   end

   // Stage three: one compare and step, then remove the bias
   always_comb begin
      den  = cub_b_ff ? UW'(27) : UW'(9);
      qden = cub_b_ff ? (UW'(qe_ff) * UW'(27)) : (UW'(qe_ff) * UW'(9));
      rem  = u_b_ff - qden;
      q    = qe_ff + COORD_WIDTH'(rem >= den);
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         u_a_ff   <= dividend;
         cub_a_ff <= cubic;
      end
      if (en.est) begin
         qe_ff    <= qe_in;
         u_b_ff   <= u_a_ff;
         cub_b_ff <= cub_a_ff;
      end
      if (en.fix) begin
         quot <= {~q[COORD_WIDTH-1], q[COORD_WIDTH-2:0]};
      end
   end

endmodule

[src/glyph_outline_flattener.sv]
// Glyph outline flattener top level: pen state, curve pipeline, result buffer.
// Depends on glof_pkg and glof_div.
//
//   channel  direction  handshake           beat contents
//   req_     in         req_valid/req_stall action, end point, two control points
//   rsp_     out        rsp_valid/rsp_stall kind, vertex x/y, last
//
// Commands pass the entry register and the mul, est and fix stages before output.
// While rsp_stall is low the result buffer sends one beat per cycle: moves and
// lines sustain one command per cycle, a move that breaks a contour gives two
// beats, a curve three. Commands with no result never enter the pipeline.
// Reset is synchronous and active high; it clears the pen and all valid bits.
// A stall on rsp_ backs up through the pipeline to req_stall.
module glyph_outline_flattener #(
   parameter int COORD_WIDTH = glof_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic signed [COORD_WIDTH-1:0] req_to_x,
   input  logic signed [COORD_WIDTH-1:0] req_to_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl1_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl1_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl2_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl2_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic                          rsp_last
);
   import glof_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int UW = CW + 5;   // biased numerator width
   localparam int SW = CW + 6;   // signed working width for the weighted sums
   // Rounding offset (half the divisor) plus a bias that makes numerators positive
   localparam logic [SW-1:0] BIAS9  = (SW'(9)  << (CW - 1)) + SW'(4);
   localparam logic [SW-1:0] BIAS27 = (SW'(27) << (CW - 1)) + SW'(13);

   // Weighted curve point numerator, biased so it divides as an unsigned value
   function automatic logic [UW-1:0] curve_num(
      input logic signed [CW-1:0] p,
      input logic signed [CW-1:0] c1,
      input logic signed [CW-1:0] c2,
      input logic signed [CW-1:0] e,
      input logic                 cubic,
      input logic                 late
   );
      logic [SW-1:0] ps, c1s, c2s, es, sum;
      ps  = {{(SW-CW){p[CW-1]}},  p};
      c1s = {{(SW-CW){c1[CW-1]}}, c1};
      c2s = {{(SW-CW){c2[CW-1]}}, c2};
      es  = {{(SW-CW){e[CW-1]}},  e};
      if (!cubic && !late) begin
         sum = (ps << 2) + (c1s << 2) + es + BIAS9;
      end else if (!cubic) begin
         sum = ps + (c1s << 2) + (es << 2) + BIAS9;
      end else if (!late) begin
         sum = (ps << 3) + (c1s << 3) + (c1s << 2) + (c2s << 2) + (c2s << 1) + es + BIAS27;
      end else begin
         sum = ps + (c1s << 2) + (c1s << 1) + (c2s << 3) + (c2s << 2) + (es << 3) + BIAS27;
      end
      return sum[UW-1:0];
   endfunction

   // Pen state
   logic signed [CW-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic                 in_cont_ff, in_cont_in;

   // Pipeline control
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       go1, go2, go3, fin, acc;
   logic       has_out, is_cubic, same_pt;
   logic [1:0] idx_ff, idx_in, last_idx;
   glof_mode_type mode_new, mode1_ff, mode2_ff, mode3_ff, mode4_ff;
   glof_en_type   den;

   // Stage payload
   logic signed [CW-1:0] tx1_ff, ty1_ff, tx2_ff, ty2_ff, tx3_ff, ty3_ff, tx4_ff, ty4_ff;
   logic                 cub1_ff;
   logic [UW-1:0]        num_in [4];
   logic [UW-1:0]        num_ff [4];
   logic signed [CW-1:0] quot [4];   // a_x, a_y, b_x, b_y

   // Handshake and stage advance
   always_comb begin
      fin       = v4_ff && !rsp_stall && rsp_last;
      go3       = v3_ff && (!v4_ff || fin);
      go2       = v2_ff && (!v3_ff || go3);
      go1       = v1_ff && (!v2_ff || go2);
      req_stall = v1_ff && !go1;
      acc       = req_valid && !req_stall;
      den.mul   = go1;
      den.est   = go2;
      den.fix   = go3;
   end

   // Command decode and pen update
   always_comb begin
      same_pt    = (pen_x_ff == req_to_x) && (pen_y_ff == req_to_y);
      has_out    = 1'b0;
      is_cubic   = 1'b0;
      mode_new   = MODE_VERTEX;
      pen_x_in   = pen_x_ff;
      pen_y_in   = pen_y_ff;
      in_cont_in = in_cont_ff;
      case (req_action)
         ACT_MOVE: begin
            if (!in_cont_ff || !same_pt) begin
               has_out    = 1'b1;
               mode_new   = in_cont_ff ? MODE_MARKER : MODE_VERTEX;
               in_cont_in = 1'b1;
               pen_x_in   = req_to_x;
               pen_y_in   = req_to_y;
            end
         end
         ACT_LINE: begin
            if (!same_pt) begin
               has_out  = 1'b1;
               pen_x_in = req_to_x;
               pen_y_in = req_to_y;
            end
         end
         ACT_CONIC, ACT_CUBIC: begin
            has_out  = 1'b1;
            is_cubic = (req_action == ACT_CUBIC);
            mode_new = MODE_CURVE;
            pen_x_in = req_to_x;
            pen_y_in = req_to_y;
         end
         ACT_GLYPH: begin
            pen_x_in   = '0;
            pen_y_in   = '0;
            in_cont_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Curve numerators from the pen before this command
   always_comb begin
      num_in[0] = curve_num(pen_x_ff, req_ctrl1_x, req_ctrl2_x, req_to_x, is_cubic, 1'b0);
      num_in[1] = curve_num(pen_y_ff, req_ctrl1_y, req_ctrl2_y, req_to_y, is_cubic, 1'b0);
      num_in[2] = curve_num(pen_x_ff, req_ctrl1_x, req_ctrl2_x, req_to_x, is_cubic, 1'b1);
      num_in[3] = curve_num(pen_y_ff, req_ctrl1_y, req_ctrl2_y, req_to_y, is_cubic, 1'b1);
   end

   // Beat index within the result buffer
   always_comb begin
      case (mode4_ff)
         MODE_VERTEX: last_idx = 2'd0;
         MODE_MARKER: last_idx = 2'd1;
         default:     last_idx = 2'd2;
      endcase
      idx_in = idx_ff;
      if (go3) begin
         idx_in = 2'd0;
      end else if (v4_ff && !rsp_stall) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // Result beat selection
   always_comb begin
      rsp_valid = v4_ff;
      rsp_last  = (idx_ff == last_idx);
      rsp_kind  = (mode4_ff == MODE_MARKER) && (idx_ff == 2'd0);
      rsp_out_x = tx4_ff;
      rsp_out_y = ty4_ff;
      if (rsp_kind) begin
         rsp_out_x = '0;
         rsp_out_y = '0;
      end else if (mode4_ff == MODE_CURVE && idx_ff == 2'd0) begin
         rsp_out_x = quot[0];
         rsp_out_y = quot[1];
      end else if (mode4_ff == MODE_CURVE && idx_ff == 2'd1) begin
         rsp_out_x = quot[2];
         rsp_out_y = quot[3];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         in_cont_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         idx_ff     <= 2'd0;
      end else begin
         if (acc) begin
            pen_x_ff   <= pen_x_in;
            pen_y_ff   <= pen_y_in;
            in_cont_ff <= in_cont_in;
         end
         v1_ff  <= (v1_ff && !go1) || (acc && has_out);
         v2_ff  <= (v2_ff && !go2) || go1;
         v3_ff  <= (v3_ff && !go3) || go2;
         v4_ff  <= (v4_ff && !fin) || go3;
         idx_ff <= idx_in;
      end
   end

   // Stage payload registers
   always_ff @(posedge clock) begin
      if (acc && has_out) begin
         mode1_ff <= mode_new;
         tx1_ff   <= req_to_x;
         ty1_ff   <= req_to_y;
         cub1_ff  <= is_cubic;
         num_ff   <= num_in;
      end
      if (go1) begin
         mode2_ff <= mode1_ff;
         tx2_ff   <= tx1_ff;
         ty2_ff   <= ty1_ff;
      end
      if (go2) begin
         mode3_ff <= mode2_ff;
         tx3_ff   <= tx2_ff;
         ty3_ff   <= ty2_ff;
      end
      if (go3) begin
         mode4_ff <= mode3_ff;
         tx4_ff   <= tx3_ff;
         ty4_ff   <= ty3_ff;
      end
   end

   // One divider per interior coordinate
   for (genvar g = 0; g < 4; g++) begin : g_div
      glof_div #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_div (
         .clock   (clock),
         .en      (den),
         .cubic   (cub1_ff),
         .dividend(num_ff[g]),
         .quot    (quot[g])
      );
   end

`ifndef SYNTHESIS
   // Beat index never runs past the last beat of the buffered command
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff <= last_idx))
      else $error("result beat index past last beat");

   // A contour marker is always followed by its vertex
   a_marker_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> !rsp_last)
      else $error("marker flagged as last beat");

   // An accepted command with results occupies the first stage next cycle
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (acc && has_out) |=> v1_ff)
      else $error("accepted command lost at pipeline entry");

   // A curve leaves the pen on its end point
   a_curve_pen: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_action == ACT_CONIC || req_action == ACT_CUBIC))
      |=> (pen_x_ff == $past(req_to_x) && pen_y_ff == $past(req_to_y)))
      else $error("pen not moved to curve end point");
`endif

endmodule

[tb/sv/glyph_outline_flattener_tb.sv]
// Self-checking testbench for glyph_outline_flattener: directed and random outline commands.
// Depends on glof_pkg and the glyph_outline_flattener RTL; vertices are predicted in-bench.
`timescale 1ns / 1ps

module glyph_outline_flattener_tb;
   import glof_pkg::*;

   localparam int CW = COORD_WIDTH_DEFAULT;
   localparam logic [2:0] FIRST_RESERVED_ACTION = 3'd5;
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      logic [2:0] action;
      coord_type  to_x, to_y, c1_x, c1_y, c2_x, c2_y;
   } outline_cmd_type;

   typedef struct {
      logic      kind;
      coord_type x, y;
      logic      last;
   } vertex_beat_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_action;
   coord_type  req_to_x, req_to_y, req_ctrl1_x, req_ctrl1_y, req_ctrl2_x, req_ctrl2_y;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   coord_type  rsp_out_x, rsp_out_y;
   logic       rsp_last;

   // Predicted pen state and outstanding vertices
   coord_type       pen_x, pen_y;
   bit              contour_open;
   vertex_beat_type pending_vertices[$];
   int              mismatch_count = 0;
   bit              steady_run = 1'b0;

   glyph_outline_flattener #(.COORD_WIDTH(CW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_to_x    (req_to_x),
      .req_to_y    (req_to_y),
      .req_ctrl1_x (req_ctrl1_x),
      .req_ctrl1_y (req_ctrl1_y),
      .req_ctrl2_x (req_ctrl2_x),
      .req_ctrl2_y (req_ctrl2_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_last    (rsp_last)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("** glyph_outline_flattener: FAILED **");
      $finish;
   end

   // Receiver back-pressure, off during the steady stretch
   always @(negedge clock) begin
      rsp_stall <= !steady_run && ($urandom_range(0, 99) < 8);
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   // Nearest integer to num/den, ties upward (den > 0)
   function automatic coord_type nearest_ratio(input longint num, input longint den);
      longint n2, d2, q;
      n2 = 2 * num + den;
      d2 = 2 * den;
      q = n2 / d2;
      if ((n2 % d2 != 0) && (n2 < 0))
         q = q - 1;
      return coord_type'(q);
   endfunction

   function automatic void expect_vertex(input logic kind, input coord_type x,
                                         input coord_type y, input logic last);
      pending_vertices.push_back('{kind: kind, x: x, y: y, last: last});
   endfunction

   // Work out the beats one command causes and advance the pen
   function automatic void predict_vertices(input outline_cmd_type c);
      longint px, py, tx, ty, ax, ay, bx, by;
      px = longint'(pen_x);
      py = longint'(pen_y);
      tx = longint'(c.to_x);
      ty = longint'(c.to_y);
      ax = longint'(c.c1_x);
      ay = longint'(c.c1_y);
      bx = longint'(c.c2_x);
      by = longint'(c.c2_y);
      case (c.action)
         ACT_MOVE: begin
            if (!contour_open || pen_x != c.to_x || pen_y != c.to_y) begin
               if (contour_open)
                  expect_vertex(KIND_MARKER, '0, '0, 1'b0);
               contour_open = 1'b1;
               pen_x = c.to_x;
               pen_y = c.to_y;
               expect_vertex(KIND_VERTEX, c.to_x, c.to_y, 1'b1);
            end
         end
         ACT_LINE: begin
            if (pen_x != c.to_x || pen_y != c.to_y) begin
               pen_x = c.to_x;
               pen_y = c.to_y;
               expect_vertex(KIND_VERTEX, c.to_x, c.to_y, 1'b1);
            end
         end
         ACT_CONIC: begin
            expect_vertex(KIND_VERTEX, nearest_ratio(4 * px + 4 * ax + tx, 9),
                          nearest_ratio(4 * py + 4 * ay + ty, 9), 1'b0);
            expect_vertex(KIND_VERTEX, nearest_ratio(px + 4 * ax + 4 * tx, 9),
                          nearest_ratio(py + 4 * ay + 4 * ty, 9), 1'b0);
            expect_vertex(KIND_VERTEX, c.to_x, c.to_y, 1'b1);
            pen_x = c.to_x;
            pen_y = c.to_y;
         end
         ACT_CUBIC: begin
            expect_vertex(KIND_VERTEX, nearest_ratio(8 * px + 12 * ax + 6 * bx + tx, 27),
                          nearest_ratio(8 * py + 12 * ay + 6 * by + ty, 27), 1'b0);
            expect_vertex(KIND_VERTEX, nearest_ratio(px + 6 * ax + 12 * bx + 8 * tx, 27),
                          nearest_ratio(py + 6 * ay + 12 * by + 8 * ty, 27), 1'b0);
            expect_vertex(KIND_VERTEX, c.to_x, c.to_y, 1'b1);
            pen_x = c.to_x;
            pen_y = c.to_y;
         end
         ACT_GLYPH: begin
            pen_x = '0;
            pen_y = '0;
            contour_open = 1'b0;
         end
         default: ;  // reserved codes do nothing
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      vertex_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected beat, kind", rsp_kind, -1);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_out_x !== want.x)
               report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y)
               report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // Mostly small coordinates, some full-width and some at the rails
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return coord_type'(int'($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   // Send one command beat, with an occasional gap ahead of it
   task automatic send_cmd(input logic [2:0] action, input coord_type to_x,
                           input coord_type to_y,
                           input coord_type c1_x, input coord_type c1_y,
                           input coord_type c2_x, input coord_type c2_y);
      outline_cmd_type c;
      c = '{action: action, to_x: to_x, to_y: to_y, c1_x: c1_x, c1_y: c1_y,
            c2_x: c2_x, c2_y: c2_y};
      @(negedge clock);
      if (!steady_run && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= c.action;
      req_to_x    <= c.to_x;
      req_to_y    <= c.to_y;
      req_ctrl1_x <= c.c1_x;
      req_ctrl1_y <= c.c1_y;
      req_ctrl2_x <= c.c2_x;
      req_ctrl2_y <= c.c2_y;
      do @(posedge clock); while (req_stall);
      predict_vertices(c);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Lines with no open contour; a line to the pen gives nothing
   task automatic test_lines_without_contour();
      send_cmd(ACT_LINE, '0, '0, rand_coord(), rand_coord(), rand_coord(), rand_coord());
      send_cmd(ACT_LINE, coord_type'(5), coord_type'(-3), rand_coord(), rand_coord(),
               rand_coord(), rand_coord());
      send_cmd(ACT_LINE, coord_type'(5), coord_type'(-3), '0, '0, '0, '0);
   endtask

   // First move opens a contour, repeat gives nothing, new point gives a marker
   task automatic test_moves();
      send_cmd(ACT_MOVE, coord_type'(5), coord_type'(-3), rand_coord(), rand_coord(),
               rand_coord(), rand_coord());
      send_cmd(ACT_MOVE, coord_type'(5), coord_type'(-3), rand_coord(), rand_coord(),
               rand_coord(), rand_coord());
      send_cmd(ACT_MOVE, coord_type'(-7), coord_type'(9), rand_coord(), rand_coord(),
               rand_coord(), rand_coord());
   endtask

   // Coordinate rails through lines and both curve kinds
   task automatic test_extremes();
      send_cmd(ACT_LINE, COORD_MAX, COORD_MIN, '0, '0, '0, '0);
      send_cmd(ACT_LINE, COORD_MIN, COORD_MAX, '1, '1, '1, '1);
      send_cmd(ACT_CONIC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send_cmd(ACT_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
   endtask

   // Rounding of negative fractions and degenerate curves
   task automatic test_curves();
      send_cmd(ACT_LINE, '0, '0, '0, '0, '0, '0);
      send_cmd(ACT_CONIC, coord_type'(-5), coord_type'(-1), '0, '0, COORD_MAX, COORD_MIN);
      send_cmd(ACT_CUBIC, coord_type'(-5), coord_type'(-1), coord_type'(-5), coord_type'(-1),
               coord_type'(-5), coord_type'(-1));
      send_cmd(ACT_CUBIC, coord_type'(10), coord_type'(7), coord_type'(1), coord_type'(2),
               coord_type'(4), coord_type'(-3));
   endtask

   // Start glyph clears pen and contour; reserved codes are ignored
   task automatic test_glyph_and_reserved();
      logic [2:0] a;
      send_cmd(ACT_GLYPH, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord());
      a = FIRST_RESERVED_ACTION;
      repeat (8 - FIRST_RESERVED_ACTION) begin
         send_cmd(a, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord());
         a++;
      end
      send_cmd(ACT_MOVE, '0, '0, '0, '0, '0, '0);
      send_cmd(ACT_LINE, coord_type'(3), coord_type'(3), '0, '0, '0, '0);
      send_cmd(ACT_GLYPH, '0, '0, '0, '0, '0, '0);
      send_cmd(ACT_LINE, '0, '0, '0, '0, '0, '0);
   endtask

   // Mostly well-formed glyphs with random content, plus raw noise
   task automatic test_random_outlines();
      int       done_cmds;
      int       pick;
      bit       drained;
      logic [2:0] act;
      done_cmds = 0;
      drained = 1'b0;
      while (done_cmds < 140) begin
         steady_run = (done_cmds >= 60 && done_cmds < 100);
         // hold off once until everything has come back
         if (!drained && done_cmds >= 110) begin
            idle_req();
            wait_drained();
            drained = 1'b1;
         end
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 1)) begin
               send_cmd(ACT_GLYPH, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord());
               done_cmds++;
            end
            repeat ($urandom_range(1, 3)) begin
               send_cmd(ACT_MOVE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord());
               done_cmds++;
               repeat ($urandom_range(2, 6)) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 15) begin
                     // back to the pen position
                     act = $urandom_range(0, 1) ? ACT_MOVE : ACT_LINE;
                     send_cmd(act, pen_x, pen_y, rand_coord(), rand_coord(),
                              rand_coord(), rand_coord());
                  end else if (pick < 45) begin
                     send_cmd(ACT_LINE, rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord());
                  end else if (pick < 70) begin
                     send_cmd(ACT_CONIC, rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord());
                  end else begin
                     send_cmd(ACT_CUBIC, rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord());
                  end
                  done_cmds++;
               end
            end
         end else begin
            act = 3'($urandom_range(0, 7));
            send_cmd(act, coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom));
            if (act <= ACT_GLYPH)
               done_cmds++;
         end
      end
      steady_run = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = '0;
      req_to_x     = '0;
      req_to_y     = '0;
      req_ctrl1_x  = '0;
      req_ctrl1_y  = '0;
      req_ctrl2_x  = '0;
      req_ctrl2_y  = '0;
      pen_x        = '0;
      pen_y        = '0;
      contour_open = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_lines_without_contour();
      test_moves();
      test_extremes();
      test_curves();
      test_glyph_and_reserved();
      test_random_outlines();
      idle_req();

      // let the pipeline settle after the last expected beat
      wait_drained();
      repeat (16) @(posedge clock);

      if (mismatch_count == 0 && pending_vertices.size() == 0) begin
         $display("** glyph_outline_flattener: PASSED **");
      end else begin
         $display("** glyph_outline_flattener: FAILED **");
      end
      $finish;
   end

endmodule
